/* rtl/smpq_pkg.sv */
// ============================================================================
// smpq_pkg
// Shared types and constants of the sorted max-priority queue.
// ============================================================================
package smpq_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OCC_W    = 8;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                     insert;
    logic                     remove;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

/* rtl/smpq_if.sv */
// ============================================================================
// smpq_if
// Valid/ready channels of the sorted max-priority queue.
// ============================================================================
interface smpq_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic signed [smpq_pkg::DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface smpq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [smpq_pkg::DATA_W-1:0] removed_value;
  logic [1:0]                         status;
  logic [smpq_pkg::OCC_W-1:0]         occupancy;
  logic                               is_empty;
  logic                               is_full;

  modport source (output valid, output removed_value, output status, output occupancy,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input removed_value, input status, input occupancy,
                  input is_empty, input is_full, output ready);
endinterface

/* rtl/smpq_cell.sv */
// ============================================================================
// smpq_cell
// One slot of the sorted chain: holds a value, shifts on insert or remove.
// ============================================================================
module smpq_cell (
  input  logic                               clk_i,
  input  smpq_pkg::cmd_t                     cmd_i,
  input  logic [smpq_pkg::IDX_W-1:0]         idx_i,
  input  logic [smpq_pkg::CNT_W-1:0]         count_i,
  input  logic signed [smpq_pkg::DATA_W-1:0] prev_value_i,
  input  logic                               prev_keep_i,
  input  logic signed [smpq_pkg::DATA_W-1:0] next_value_i,
  output logic signed [smpq_pkg::DATA_W-1:0] value_o,
  output logic                               keep_o
);

  logic signed [smpq_pkg::DATA_W-1:0] value_q, value_d;
  logic                               occupied;

  assign occupied = smpq_pkg::CNT_W'(idx_i) < count_i;
  // stored value stays in place when it is not below the new one
  assign keep_o   = occupied && !(cmd_i.value > value_q);
  assign value_o  = value_q;

  always_comb begin
    value_d = value_q;
    if (cmd_i.insert && !keep_o) begin
      value_d = prev_keep_i ? cmd_i.value : prev_value_i;
    end else if (cmd_i.remove) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

/* rtl/sorted_max_priority_queue.sv */
// ============================================================================
// sorted_max_priority_queue
// Bounded max-priority queue of signed 32-bit values in a sorted cell chain.
// ============================================================================
// usage
//   in_i  : one transfer is one command, operation 0 inserts value, 1 removes
//           the largest stored value (value is ignored then)
//   out_o : exactly one result transfer per command: removed value (0 unless
//           a remove succeeded), status (ok, overflow, underflow), occupancy
//           and empty/full flags as they stand after the command
//   result: registered, valid in the cycle after the command transfer
//   throughput: one command per cycle while out_o.ready is high; every cell compares the broadcast
//           value with its own entry and shifts toward its neighbor in the
//           same cycle, so the chain is updated before the next command
//   an insert into a full queue drops the value and reports overflow; a
//   remove from an empty queue changes nothing and reports underflow
//   reset: the queue is empty and no result is pending; stored values are
//           left as they are and only ever read below the count
//   stall: the single output register holds its result while out_o.ready is
//           low; in_i.ready is high when that register is empty or drains
//           in the same cycle
// ============================================================================
module sorted_max_priority_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  smpq_in_if.sink          in_i,
  smpq_out_if.source       out_o
);

  localparam int unsigned N = smpq_pkg::CAPACITY;

  // ---------------------------------------------------------------- control
  logic                          in_xfer;
  logic                          out_valid_q;
  logic [smpq_pkg::CNT_W-1:0]    count_q, count_d;
  logic                          full, empty;
  logic                          do_insert, do_remove;
  smpq_pkg::cmd_t                cmd;
  smpq_pkg::status_e             status_d;
  logic signed [smpq_pkg::DATA_W-1:0] removed_d;

  // result register
  logic signed [smpq_pkg::DATA_W-1:0] removed_q;
  smpq_pkg::status_e             status_q;
  logic [smpq_pkg::OCC_W-1:0]    occ_q;
  logic                          empty_q, full_q;

  // chain wiring
  logic signed [smpq_pkg::DATA_W-1:0] cell_value [N];
  logic                               cell_keep  [N];

  // accept a command whenever the result register is free or drains now
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  assign full  = count_q == smpq_pkg::CNT_W'(N);
  assign empty = count_q == '0;

  assign do_insert = in_xfer && (in_i.operation == smpq_pkg::OP_INSERT) && !full;
  assign do_remove = in_xfer && (in_i.operation == smpq_pkg::OP_REMOVE) && !empty;

  assign cmd.insert = do_insert;
  assign cmd.remove = do_remove;
  assign cmd.value  = in_i.value;

  // next count, status and removed head
  always_comb begin
    count_d   = count_q;
    status_d  = smpq_pkg::ST_OK;
    removed_d = '0;
    if (in_i.operation == smpq_pkg::OP_INSERT) begin
      if (full) begin
        status_d = smpq_pkg::ST_OVERFLOW;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = smpq_pkg::ST_UNDERFLOW;
      end else begin
        count_d   = count_q - 1'b1;
        removed_d = cell_value[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_q <= count_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      removed_q <= removed_d;
      status_q  <= status_d;
      occ_q     <= smpq_pkg::OCC_W'(count_d);
      empty_q   <= count_d == '0;
      full_q    <= count_d == smpq_pkg::CNT_W'(N);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.removed_value = removed_q;
  assign out_o.status        = status_q;
  assign out_o.occupancy     = occ_q;
  assign out_o.is_empty      = empty_q;
  assign out_o.is_full       = full_q;

  // ------------------------------------------------------------ cell chain
  // head is cell 0 (largest); each cell looks at its left neighbor on an
  // insert and at its right neighbor on a remove
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [smpq_pkg::DATA_W-1:0] prev_value, next_value;
    logic                               prev_keep;

    if (i == 0) begin : g_head
      assign prev_value = cmd.value;
      assign prev_keep  = 1'b0;
    end else begin : g_mid
      assign prev_value = cell_value[i-1];
      assign prev_keep  = cell_keep[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign next_value = cell_value[i];
    end else begin : g_body
      assign next_value = cell_value[i+1];
    end

    smpq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .idx_i        (smpq_pkg::IDX_W'(i)),
      .count_i      (count_q),
      .prev_value_i (prev_value),
      .prev_keep_i  (prev_keep),
      .next_value_i (next_value),
      .value_o      (cell_value[i]),
      .keep_o       (cell_keep[i])
    );
  end

  // -------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= smpq_pkg::CNT_W'(N))
    else $error("count above capacity");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= smpq_pkg::CNT_W'(2) |-> cell_value[0] >= cell_value[1])
    else $error("head not the largest entry");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("command transfer gave no result");

  a_underflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == smpq_pkg::ST_UNDERFLOW |-> removed_q == '0 && empty_q)
    else $error("underflow result not clean");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(count_q))
    else $error("count changed without a command");

endmodule

/* tb/smpq_scoreboard_pkg.sv */
// ============================================================================
// smpq_scoreboard_pkg
// Scoreboard of the sorted max-priority queue: keeps a descending copy of
// the stored values and checks every result transfer in order.
// ============================================================================
package smpq_scoreboard_pkg;

  typedef struct {
    logic signed [smpq_pkg::DATA_W-1:0] removed_value;
    smpq_pkg::status_e                  status;
    logic [smpq_pkg::OCC_W-1:0]         occupancy;
    logic                               is_empty;
    logic                               is_full;
  } queue_result_t;

  class queue_scoreboard;
    logic signed [smpq_pkg::DATA_W-1:0] sorted_values[$];  // largest first
    queue_result_t                      expected_results[$];
    int unsigned                        errors;
    int unsigned                        results_seen;

    function new();
      errors       = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // accepted command: update the shadow queue and queue its result
    function void note_command(smpq_pkg::op_e op, logic signed [smpq_pkg::DATA_W-1:0] value);
      queue_result_t r;
      int            pos;
      r.removed_value = '0;
      r.status        = smpq_pkg::ST_OK;
      if (op == smpq_pkg::OP_INSERT) begin
        if (sorted_values.size() >= smpq_pkg::CAPACITY) begin
          r.status = smpq_pkg::ST_OVERFLOW;
        end else begin
          // equal values stay ahead of the new one
          pos = 0;
          while (pos < sorted_values.size() && !(value > sorted_values[pos])) pos++;
          sorted_values.insert(pos, value);
        end
      end else begin
        if (sorted_values.size() == 0) begin
          r.status = smpq_pkg::ST_UNDERFLOW;
        end else begin
          r.removed_value = sorted_values.pop_front();
        end
      end
      r.occupancy = smpq_pkg::OCC_W'(sorted_values.size());
      r.is_empty  = (sorted_values.size() == 0);
      r.is_full   = (sorted_values.size() >= smpq_pkg::CAPACITY);
      expected_results.push_back(r);
    endfunction

    task report(string what, logic [smpq_pkg::DATA_W-1:0] want,
                logic [smpq_pkg::DATA_W-1:0] got);
      errors++;
      $display("result %0d: %s expected %h got %h", results_seen, what, want, got);
    endtask

    task check_result(queue_result_t got);
      queue_result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report("result with no command pending", '0, got.removed_value);
        return;
      end
      want = expected_results.pop_front();
      if (got.removed_value !== want.removed_value)
        report("removed_value", want.removed_value, got.removed_value);
      if (got.status !== want.status)
        report("status", smpq_pkg::DATA_W'(want.status), smpq_pkg::DATA_W'(got.status));
      if (got.occupancy !== want.occupancy)
        report("occupancy", smpq_pkg::DATA_W'(want.occupancy),
               smpq_pkg::DATA_W'(got.occupancy));
      if (got.is_empty !== want.is_empty)
        report("is_empty", smpq_pkg::DATA_W'(want.is_empty),
               smpq_pkg::DATA_W'(got.is_empty));
      if (got.is_full !== want.is_full)
        report("is_full", smpq_pkg::DATA_W'(want.is_full),
               smpq_pkg::DATA_W'(got.is_full));
    endtask
  endclass

endpackage

/* tb/tb.sv */
// ============================================================================
// tb
// Self-checking bench of the sorted max-priority queue: directed corner
// commands, then random fill and drain phases with random idling on both
// channels, every result checked against a shadow sorted queue.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // generous bound: many times what about 1000 commands need at worst
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 130;

  logic clk_i;
  logic rst_ni;

  smpq_in_if  in_ch ();
  smpq_out_if out_ch ();

  sorted_max_priority_queue uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  smpq_scoreboard_pkg::queue_scoreboard sb = new();

  // per-phase switches: off gives stretches without idling on that side
  bit          sender_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  int unsigned cycles      = 0;

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // value mix: mostly full-range, some extremes, some narrow range for ties
  function automatic logic signed [smpq_pkg::DATA_W-1:0] pick_value();
    logic signed [smpq_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh7fff_ffff;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          3:       v = '1;
          default: v = 32'sd1;
        endcase
      end
      1, 2:    v = $signed(smpq_pkg::DATA_W'($urandom_range(0, 15)) - smpq_pkg::DATA_W'(8));
      default: v = $signed($urandom);
    endcase
    return v;
  endfunction

  // one command transfer; valid stays high on return so back-to-back
  // commands go out without a bubble
  task automatic drive_command(smpq_pkg::op_e op, logic signed [smpq_pkg::DATA_W-1:0] value);
    int unsigned gap;
    gap = sender_gaps ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= value;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_command(op, value);
  endtask

  // hold off the sender until every result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side: sample at the edge, then draw a stall after each transfer
  initial begin : result_sink
    int unsigned                         hold;
    smpq_scoreboard_pkg::queue_result_t  got;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.removed_value = out_ch.removed_value;
        got.status        = smpq_pkg::status_e'(out_ch.status);
        got.occupancy     = out_ch.occupancy;
        got.is_empty      = out_ch.is_empty;
        got.is_full       = out_ch.is_full;
        sb.check_result(got);
        hold = sink_stalls ? $urandom_range(0, 19) : 0;
      end
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    // insert share per phase: fill into overflow, drain into underflow, then mixed
    int unsigned   insert_pct [7] = '{90, 95, 10, 5, 50, 80, 15};
    smpq_pkg::op_e op;

    rst_ni = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= smpq_pkg::OP_INSERT;
    in_ch.value     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: remove from an empty queue right after reset
    drive_command(smpq_pkg::OP_REMOVE, $signed($urandom));
    // extremes and ties, the equal ones land behind the older copies
    drive_command(smpq_pkg::OP_INSERT, '0);
    drive_command(smpq_pkg::OP_INSERT, 32'sh7fff_ffff);
    drive_command(smpq_pkg::OP_INSERT, 32'sh8000_0000);
    drive_command(smpq_pkg::OP_INSERT, '1);
    drive_command(smpq_pkg::OP_INSERT, 32'sd1);
    drive_command(smpq_pkg::OP_INSERT, '0);
    drive_command(smpq_pkg::OP_INSERT, 32'sh7fff_ffff);
    drive_command(smpq_pkg::OP_INSERT, 32'sh8000_0000);
    // drain past empty, ignored value field carries noise
    repeat (9) drive_command(smpq_pkg::OP_REMOVE, $signed($urandom));
    drive_command(smpq_pkg::OP_INSERT, 32'sh5555_5555);
    drive_command(smpq_pkg::OP_INSERT, 32'shaaaa_aaaa);
    repeat (3) drive_command(smpq_pkg::OP_REMOVE, $signed($urandom));

    // sender waits for every result before the random part
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      sender_gaps = (p % 3 != 1);
      sink_stalls = (p % 3 != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(1, 100) <= insert_pct[p]) ? smpq_pkg::OP_INSERT
                                                        : smpq_pkg::OP_REMOVE;
        drive_command(op, pick_value());
      end
      if ($urandom_range(0, 1) == 1) wait_drained();
    end

    // everything accepted: wait out the results, then let the clock run on before the end
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    wait_drained();
    repeat (5) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sorted_max_priority_queue.f */
rtl/smpq_pkg.sv
rtl/smpq_if.sv
rtl/smpq_cell.sv
rtl/sorted_max_priority_queue.sv
tb/smpq_scoreboard_pkg.sv
tb/tb.sv
